FILE: rtl/bpc_pkg.sv
// Shared types and constants for the BCH Peterson/Chien decoder.
// No dependencies; imported by the top level, the locator, the merge stage and the bench.
`timescale 1ns / 1ps
package bpc_pkg;
	localparam int WORD_BITS = 31;
	localparam int CNT_BITS  = 3;
	localparam int CNT_MAX   = 7;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [2:0]           tcap_t;
	typedef logic [6:0]           fpoly_t;

	// Configuration register indexes (byte address / 4)
	typedef enum logic {
		REG_MAX_CORRECT = 1'b0,
		REG_FIELD_POLY  = 1'b1
	} reg_idx_t;

	localparam tcap_t  MAX_CORRECT_RST = 3'd3;
	localparam fpoly_t FIELD_POLY_RST  = 7'd37;

	localparam tcap_t T_ONE   = 3'd1;
	localparam tcap_t T_TWO   = 3'd2;
	localparam tcap_t T_THREE = 3'd3;
	localparam tcap_t T_FOUR  = 3'd4;
endpackage

FILE: rtl/bpc_gf_inv.sv
// Pipelined GF(2^M) inverse as x^(2^M-2) by repeated square and multiply.
// Standalone; used by bpc_locator. Zero maps to zero.
`timescale 1ns / 1ps
module bpc_gf_inv #(
	parameter int M = 5
) (
	input  logic         clk,
	input  logic [M-2:0] en,
	input  logic [M-1:0] poly,
	input  logic [M-1:0] x,
	output logic [M-1:0] y
);
	logic [M-1:0] p_q   [M-1];
	logic [M-1:0] acc_q [M-1];

	function automatic logic [M-1:0] gmul(input logic [M-1:0] a, input logic [M-1:0] b,
			input logic [M-1:0] pl);
		logic [M-1:0] r;
		logic [M-1:0] s;
		r = '0;
		s = a;
		for (int i = 0; i < M; i++) begin
			if (b[i]) r = r ^ s;
			s = {s[M-2:0], 1'b0} ^ (s[M-1] ? pl : '0);
		end
		return r;
	endfunction

	// first stage: x^2
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_q[0]   <= gmul(x, x, poly);
			acc_q[0] <= gmul(x, x, poly);
		end
	end

	// later stages: square the power, fold it into the product
	for (genvar k = 1; k < M - 1; k++) begin : g_stage
		logic [M-1:0] sq;
		assign sq = gmul(p_q[k-1], p_q[k-1], poly);
		always_ff @(posedge clk) begin
			if (en[k]) begin
				p_q[k]   <= sq;
				acc_q[k] <= gmul(acc_q[k-1], sq, poly);
			end
		end
	end

	assign y = acc_q[M-2];
endmodule

FILE: rtl/bpc_locator.sv
// Error locator pipeline: powers of S1, Peterson closed forms for t = 1..4,
// and two field inverters. Depends on bpc_pkg and bpc_gf_inv.
`timescale 1ns / 1ps
module bpc_locator #(
	parameter int M = 5
) (
	input  logic                  clk,
	input  logic [M+5:0]          en,
	input  logic [M-1:0]          poly,
	input  bpc_pkg::tcap_t        tcap,
	input  logic [3:0][M-1:0]     syn,
	input  bpc_pkg::word_t        word_in,
	output logic [3:0][M-1:0]     lam,
	output bpc_pkg::word_t        word_out
);
	import bpc_pkg::*;

	localparam int IS = 4;       // first inverter stage
	localparam int IE = M + 2;   // last inverter stage

	typedef struct packed {
		logic [M-1:0] num;
		logic [M-1:0] s1;
		logic [M-1:0] s1c;
		logic [M-1:0] s3;
		logic [M-1:0] s5;
		logic [M-1:0] m13;
		word_t        word;
	} side_t;

	function automatic logic [M-1:0] gmul(input logic [M-1:0] a, input logic [M-1:0] b,
			input logic [M-1:0] pl);
		logic [M-1:0] r;
		logic [M-1:0] s;
		r = '0;
		s = a;
		for (int i = 0; i < M; i++) begin
			if (b[i]) r = r ^ s;
			s = {s[M-2:0], 1'b0} ^ (s[M-1] ? pl : '0);
		end
		return r;
	endfunction

	logic [M-1:0] s1_s1, s3_s1, s5_s1, s7_s1, a2_s1;
	word_t        word_s1;
	logic [M-1:0] s1_s2, s3_s2, s5_s2, s7_s2, s1c_s2, s1q_s2, m13_s2;
	word_t        word_s2;
	logic [M-1:0] s1_s3, s3_s3, s5_s3, s7_s3, s1c_s3, m13_s3, s1f_s3, s17_s3, s33_s3;
	word_t        word_s3;
	side_t        side_s4;
	logic [M-1:0] den_s4;
	side_t        side_q [M-1];
	logic [M-1:0] inv_den, inv_s1;
	side_t        side_s5;
	logic [M-1:0] l2_s5, is1_s5;
	logic [M-1:0] l2_s6, l3_s6, q_s6, s1_s6, is1_s6;
	word_t        word_s6;
	logic [M-1:0] num_d, den_d;

	// square S1
	always_ff @(posedge clk) begin
		if (en[0]) begin
			s1_s1   <= syn[0];
			s3_s1   <= syn[1];
			s5_s1   <= syn[2];
			s7_s1   <= syn[3];
			a2_s1   <= gmul(syn[0], syn[0], poly);
			word_s1 <= word_in;
		end
	end

	// S1^3, S1^4, S1^2*S3
	always_ff @(posedge clk) begin
		if (en[1]) begin
			s1_s2   <= s1_s1;
			s3_s2   <= s3_s1;
			s5_s2   <= s5_s1;
			s7_s2   <= s7_s1;
			s1c_s2  <= gmul(a2_s1, s1_s1, poly);
			s1q_s2  <= gmul(a2_s1, a2_s1, poly);
			m13_s2  <= gmul(a2_s1, s3_s1, poly);
			word_s2 <= word_s1;
		end
	end

	// S1^5, S1^7, S3*(S3+S1^3)
	always_ff @(posedge clk) begin
		if (en[2]) begin
			s1_s3   <= s1_s2;
			s3_s3   <= s3_s2;
			s5_s3   <= s5_s2;
			s7_s3   <= s7_s2;
			s1c_s3  <= s1c_s2;
			m13_s3  <= m13_s2;
			s1f_s3  <= gmul(s1q_s2, s1_s2, poly);
			s17_s3  <= gmul(s1q_s2, s1c_s2, poly);
			s33_s3  <= gmul(s3_s2, s3_s2 ^ s1c_s2, poly);
			word_s3 <= word_s2;
		end
	end

	// pick numerator and denominator of the second coefficient
	always_comb begin
		unique case (tcap)
			T_THREE: begin
				num_d = m13_s3 ^ s5_s3;
				den_d = s1c_s3 ^ s3_s3;
			end
			T_FOUR: begin
				num_d = gmul(s1_s3, s7_s3 ^ s17_s3, poly) ^ gmul(s3_s3, s5_s3 ^ s1f_s3, poly);
				den_d = s33_s3 ^ gmul(s1_s3, s5_s3 ^ s1f_s3, poly);
			end
			default: begin
				num_d = s3_s3 ^ s1c_s3;
				den_d = s1_s3;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			side_s4 <= '{num: num_d, s1: s1_s3, s1c: s1c_s3, s3: s3_s3, s5: s5_s3,
				m13: m13_s3, word: word_s3};
			den_s4  <= den_d;
		end
	end

	bpc_gf_inv #(.M(M)) u_inv_den (
		.clk  (clk),
		.en   (en[IE:IS]),
		.poly (poly),
		.x    (den_s4),
		.y    (inv_den)
	);

	bpc_gf_inv #(.M(M)) u_inv_s1 (
		.clk  (clk),
		.en   (en[IE:IS]),
		.poly (poly),
		.x    (side_s4.s1),
		.y    (inv_s1)
	);

	// carry the side data alongside the inverters
	for (genvar k = 0; k < M - 1; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[IS+k]) side_q[k] <= (k == 0) ? side_s4 : side_q[(k == 0) ? 0 : k-1];
		end
	end

	// second coefficient
	always_ff @(posedge clk) begin
		if (en[M+3]) begin
			side_s5 <= side_q[M-2];
			l2_s5   <= gmul(side_q[M-2].num, inv_den, poly);
			is1_s5  <= inv_s1;
		end
	end

	// third coefficient and numerator of the fourth
	always_ff @(posedge clk) begin
		if (en[M+4]) begin
			l2_s6   <= l2_s5;
			l3_s6   <= side_s5.s1c ^ side_s5.s3 ^ gmul(side_s5.s1, l2_s5, poly);
			q_s6    <= side_s5.m13 ^ side_s5.s5 ^
				gmul(l2_s5, side_s5.s3 ^ side_s5.s1c, poly);
			s1_s6   <= side_s5.s1;
			is1_s6  <= is1_s5;
			word_s6 <= side_s5.word;
		end
	end

	// fourth coefficient; drop terms above t
	always_ff @(posedge clk) begin
		if (en[M+5]) begin
			lam[0]   <= (tcap >= T_ONE && tcap <= T_FOUR) ? s1_s6 : '0;
			lam[1]   <= (tcap >= T_TWO && tcap <= T_FOUR) ? l2_s6 : '0;
			lam[2]   <= (tcap == T_THREE || tcap == T_FOUR) ? l3_s6 : '0;
			lam[3]   <= (tcap == T_FOUR) ? gmul(q_s6, is1_s6, poly) : '0;
			word_out <= word_s6;
		end
	end
endmodule

FILE: rtl/bpc_lane.sv
// One Chien search lane: evaluates the locator at one field element.
// Standalone; the top level instantiates one lane per element.
`timescale 1ns / 1ps
module bpc_lane #(
	parameter int M = 5
) (
	input  logic              clk,
	input  logic              en,
	input  logic [M-1:0]      poly,
	input  logic [3:0][M-1:0] lam,
	input  logic [M-1:0]      x,
	output logic              root_s1
);
	logic [M-1:0]      v;
	logic [3:0][M-1:0] pw_q;

	function automatic logic [M-1:0] gmul(input logic [M-1:0] a, input logic [M-1:0] b,
			input logic [M-1:0] pl);
		logic [M-1:0] r;
		logic [M-1:0] s;
		r = '0;
		s = a;
		for (int i = 0; i < M; i++) begin
			if (b[i]) r = r ^ s;
			s = {s[M-2:0], 1'b0} ^ (s[M-1] ? pl : '0);
		end
		return r;
	endfunction

	// powers x, x^2, x^3, x^4 by multiplication; x and x^2 are registered from the
	// table entry, x^3 and x^4 from the registered x and x^2, well before a word reaches the lanes
	always_ff @(posedge clk) begin
		pw_q[0] <= x;
		pw_q[1] <= gmul(x, x, poly);
		pw_q[2] <= gmul(pw_q[1], pw_q[0], poly);
		pw_q[3] <= gmul(pw_q[1], pw_q[1], poly);
	end

	// 1 + L1 x + L2 x^2 + L3 x^3 + L4 x^4
	always_comb begin
		v = {{(M-1){1'b0}}, 1'b1};
		for (int k = 0; k < 4; k++) v = v ^ gmul(lam[k], pw_q[k], poly);
	end

	always_ff @(posedge clk) begin
		if (en) root_s1 <= (v == '0);
	end
endmodule

FILE: rtl/bpc_merge.sv
// Merge stage: flips the bit of every root the lanes found and counts roots.
// Depends on bpc_pkg.
`timescale 1ns / 1ps
module bpc_merge #(
	parameter int M = 5
) (
	input  logic               clk,
	input  logic               en,
	input  logic [(2**M)-2:0]  root,
	input  bpc_pkg::word_t     word_in,
	output bpc_pkg::word_t     corrected_word,
	output bpc_pkg::cnt_t      error_count
);
	import bpc_pkg::*;

	localparam int N  = (2**M) - 1;
	localparam int CW = $clog2(N + 1);

	word_t         flip;
	logic [CW-1:0] sum;

	// root alpha^e marks position (n - e) mod n
	always_comb begin
		flip = '0;
		sum  = '0;
		for (int e = 0; e < N; e++) begin
			if (((N - e) % N) < WORD_BITS) flip[(N - e) % N] = flip[(N - e) % N] ^ root[e];
			sum = sum + CW'(root[e]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			corrected_word <= word_in ^ flip;
			error_count    <= (sum > CW'(CNT_MAX)) ? cnt_t'(CNT_MAX) : cnt_t'(sum);
		end
	end
endmodule

FILE: rtl/bch_peterson_chien_decoder_top.sv
// Binary BCH decoder, n = 2^FIELD_BITS-1, Peterson forms for t = 1..4 and a
// fully parallel Chien search. One word is accepted per cycle when the output
// side keeps up; the pipeline has FIELD_BITS+9 register stages, set by the
// locator pipeline (field inverters take FIELD_BITS-1 stages). Outside a
// table rebuild, the input stalls only when every stage holds a word and the
// output is not taken. After reset and after every write of field_poly the
// power table of 2^FIELD_BITS-1 entries is rebuilt, and no word is accepted
// during the rebuild. Depends on bpc_pkg and all bpc_ modules.
`timescale 1ns / 1ps
module bch_peterson_chien_decoder_top #(
	parameter int FIELD_BITS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] received_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [30:0] corrected_word, [33:31] error_count
);
	import bpc_pkg::*;

	localparam int M   = FIELD_BITS;
	localparam int N   = (2**M) - 1;
	localparam int IW  = $clog2(N);
	localparam int LEN = (N < WORD_BITS) ? N : WORD_BITS;
	localparam int P   = M + 9;

	tcap_t         tcap_q;
	fpoly_t        fpoly_q;
	logic [M-1:0]  poly;
	logic          cfg_wr;
	logic          bld_q;
	logic [IW-1:0] idx_q;
	logic [M-1:0]  cur_q;
	logic [M-1:0]  alp_q [N];
	logic [P:0]    en;
	logic [P-1:0]  v_q;
	logic [3:0][M-1:0] syn_d;
	logic [3:0][M-1:0] syn_s1;
	word_t         word_s1;
	logic [3:0][M-1:0] lam;
	word_t         lword;
	word_t         word_s2;
	logic [N-1:0]  root;
	word_t         corrected_word;
	cnt_t          error_count;

	assign poly   = fpoly_q[M-1:0];
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcap_q  <= MAX_CORRECT_RST;
			fpoly_q <= FIELD_POLY_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_MAX_CORRECT: tcap_q  <= pwdata[2:0];
				REG_FIELD_POLY:  fpoly_q <= pwdata[6:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_MAX_CORRECT: prdata = {29'd0, tcap_q};
			REG_FIELD_POLY:  prdata = {25'd0, fpoly_q};
		endcase
	end

	// rebuild the alpha power table after reset or a polynomial write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_q <= 1'b1;
			idx_q <= '0;
			cur_q <= {{(M-1){1'b0}}, 1'b1};
		end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_FIELD_POLY) begin
			bld_q <= 1'b1;
			idx_q <= '0;
			cur_q <= {{(M-1){1'b0}}, 1'b1};
		end else if (bld_q) begin
			cur_q <= {cur_q[M-2:0], 1'b0} ^ (cur_q[M-1] ? poly : '0);
			if (idx_q == IW'(N - 1)) bld_q <= 1'b0;
			else idx_q <= idx_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (bld_q) alp_q[idx_q] <= cur_q;
	end

	// per-stage advance: a stage moves when empty or when the next one moves
	always_comb begin
		en[P] = m_tready;
		for (int k = P - 1; k >= 0; k--) en[k] = !v_q[k] || en[k+1];
	end

	assign s_tready = en[0] && !bld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 0; k < P; k++) begin
				if (en[k]) v_q[k] <= (k == 0) ? (s_tvalid && !bld_q) : v_q[(k == 0) ? 0 : k-1];
			end
		end
	end

	// odd syndromes S1, S3, S5, S7 by evaluation
	always_comb begin
		for (int s = 0; s < 4; s++) begin
			syn_d[s] = '0;
			for (int i = 0; i < LEN; i++) begin
				if (s_tdata[i]) syn_d[s] = syn_d[s] ^ alp_q[IW'(((2*s + 1) * i) % N)];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			syn_s1  <= syn_d;
			word_s1 <= s_tdata[WORD_BITS-1:0];
		end
	end

	bpc_locator #(.M(M)) u_loc (
		.clk      (clk),
		.en       (en[M+6:1]),
		.poly     (poly),
		.tcap     (tcap_q),
		.syn      (syn_s1),
		.word_in  (word_s1),
		.lam      (lam),
		.word_out (lword)
	);

	// Chien search lanes, one per field element
	for (genvar e = 0; e < N; e++) begin : g_lane
		bpc_lane #(.M(M)) u_lane (
			.clk     (clk),
			.en      (en[M+7]),
			.poly    (poly),
			.lam     (lam),
			.x       (alp_q[IW'(e)]),
			.root_s1 (root[e])
		);
	end

	always_ff @(posedge clk) begin
		if (en[M+7]) word_s2 <= lword;
	end

	bpc_merge #(.M(M)) u_merge (
		.clk            (clk),
		.en             (en[M+8]),
		.root           (root),
		.word_in        (word_s2),
		.corrected_word (corrected_word),
		.error_count    (error_count)
	);

	assign m_tvalid = v_q[P-1];
	assign m_tdata  = {6'd0, error_count, corrected_word};

	// no word enters while the table is being rebuilt
	a_build_block: assert property (@(posedge clk) disable iff (!arst_n)
		bld_q |-> !s_tready) else $error("word accepted during table rebuild");

	// a polynomial write always restarts the rebuild
	a_poly_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && reg_idx_t'(paddr[2]) == REG_FIELD_POLY) |=> bld_q)
		else $error("polynomial write did not restart rebuild");

	// the rebuild ends only after the last table entry
	a_build_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(bld_q) |-> $past(idx_q) == IW'(N - 1))
		else $error("table rebuild ended early");
endmodule

FILE: tb/sv/bch_peterson_chien_decoder_top_test.sv
// Self-checking bench for the BCH Peterson/Chien decoder top level.
// Predicts each corrected word and root count in GF(2^5) arithmetic; depends on bpc_pkg.
`timescale 1ns / 1ps
module bch_peterson_chien_decoder_top_test;
	import bpc_pkg::*;

	localparam int FB   = 5;
	localparam int GN   = (1 << FB) - 1;
	localparam int LAT  = FB + 9;

	typedef struct packed {
		word_t word;
		cnt_t  roots;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	tcap_t  cur_t = MAX_CORRECT_RST;
	fpoly_t cur_poly = FIELD_POLY_RST;

	word_t    word_q[$];
	decoded_t decoded_q[$];
	int       errors = 0;
	int       hold_cycles = 0;
	int       snd_gap = 0;
	int       rcv_gap = 0;
	bit       in_acc = 1'b0;
	bit       out_acc = 1'b0;

	bch_peterson_chien_decoder_top #(.FIELD_BITS(FB)) DUT (.*);

	always #2 clk = ~clk;

	// Field arithmetic under the current polynomial, leading term forced
	function automatic logic [FB-1:0] gmul(logic [FB-1:0] a, logic [FB-1:0] b);
		logic [FB:0]   red;
		logic [FB:0]   aa;
		logic [FB-1:0] r;
		red = cur_poly[FB:0] | (1 << FB);
		aa = a;
		r = '0;
		for (int i = 0; i < FB; i++) begin
			if (b[i]) r ^= aa[FB-1:0];
			aa = aa << 1;
			if (aa[FB]) aa ^= red;
		end
		return r;
	endfunction

	function automatic logic [FB-1:0] gpow(logic [FB-1:0] a, int k);
		logic [FB-1:0] r;
		r = 1;
		for (int i = 0; i < k; i++) r = gmul(r, a);
		return r;
	endfunction

	function automatic logic [FB-1:0] gdiv(logic [FB-1:0] a, logic [FB-1:0] b);
		if (b == 0) return '0;
		return gmul(a, gpow(b, (1 << FB) - 2));
	endfunction

	function automatic decoded_t decode_word(word_t w);
		logic [FB-1:0] pw[GN];
		logic [FB-1:0] syn[9];
		logic [FB-1:0] loc[4];
		logic [FB-1:0] v, xp, s1, s3, s5, s7, s1c, s1f, num, den;
		decoded_t d;
		int tt, pos;
		d.word = w;
		d.roots = '0;
		tt = cur_t;
		pw[0] = 1;
		for (int i = 1; i < GN; i++) pw[i] = gmul(pw[i-1], 2);
		for (int i = 0; i < 9; i++) syn[i] = '0;
		for (int i = 0; i < 4; i++) loc[i] = '0;
		if (tt >= 1 && tt <= 4) begin
			for (int s = 1; s <= 2 * tt; s += 2) begin
				v = '0;
				for (int i = 0; i < GN && i < WORD_BITS; i++)
					if (w[i]) v ^= pw[(s * i) % GN];
				syn[s] = v;
			end
			for (int i = 1; i <= tt; i++) syn[2*i] = gmul(syn[i], syn[i]);
			s1 = syn[1]; s3 = syn[3]; s5 = syn[5]; s7 = syn[7];
			s1c = gpow(s1, 3);
			loc[0] = s1;
			if (tt == T_TWO) begin
				loc[1] = gdiv(s3 ^ s1c, s1);
			end else if (tt == T_THREE) begin
				loc[1] = gdiv(gmul(gmul(s1, s1), s3) ^ s5, s1c ^ s3);
				loc[2] = s1c ^ s3 ^ gmul(s1, loc[1]);
			end else if (tt == T_FOUR) begin
				s1f = gpow(s1, 5);
				num = gmul(s1, s7 ^ gpow(s1, 7)) ^ gmul(s3, s5 ^ s1f);
				den = gmul(s3, s3 ^ s1c) ^ gmul(s1, s5 ^ s1f);
				loc[1] = gdiv(num, den);
				loc[2] = s1c ^ s3 ^ gmul(s1, loc[1]);
				loc[3] = gdiv(gmul(gmul(s1, s1), s3) ^ s5 ^ gmul(loc[1], s3 ^ s1c), s1);
			end
			// Chien search over every field element
			for (int e = 0; e < GN; e++) begin
				v = 1;
				xp = 1;
				for (int i = 0; i < tt; i++) begin
					xp = gmul(xp, pw[e]);
					v ^= gmul(loc[i], xp);
				end
				if (v == 0) begin
					pos = (GN - e) % GN;
					if (d.roots < CNT_MAX) d.roots++;
					if (pos < WORD_BITS) d.word[pos] = ~d.word[pos];
				end
			end
		end
		return d;
	endfunction

	// Input sampler: record the word taken at this edge and predict its result
	always @(posedge clk) begin
		in_acc = s_tvalid && s_tready;
		if (in_acc) begin
			decoded_q = {decoded_q, decode_word(s_tdata[30:0])};
			void'(word_q.pop_front());
			snd_gap = $urandom_range(0, 9);
		end
	end

	// Driver: offer queued words with random gaps
	always @(negedge clk) begin
		if (!s_tvalid || in_acc) begin
			if (word_q.size() > 0 && snd_gap == 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {1'b0, word_q[0]};
			end else begin
				s_tvalid <= 1'b0;
				if (snd_gap > 0) snd_gap--;
			end
		end
	end

	// Monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		out_acc = m_tvalid && m_tready;
		if (out_acc) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected word %h", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata[30:0] !== decoded_q[0].word) begin
					$display("%0t: corrected_word expected %h actual %h", $time,
						decoded_q[0].word, m_tdata[30:0]);
					errors++;
				end
				if (m_tdata[33:31] !== decoded_q[0].roots) begin
					$display("%0t: error_count expected %0d actual %0d", $time,
						decoded_q[0].roots, m_tdata[33:31]);
					errors++;
				end
				void'(decoded_q.pop_front());
			end
		end
	end

	// Receiver stall: long hold-off when asked, else random per word
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else if (out_acc) begin
			rcv_gap = $urandom_range(0, 9);
			m_tready <= (rcv_gap == 0);
		end else if (rcv_gap > 0) begin
			rcv_gap--;
			m_tready <= (rcv_gap == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_MAX_CORRECT) cur_t = val[2:0];
		else cur_poly = val[6:0];
	endtask

	task automatic queue_word(word_t w);
		word_q = {word_q, w};
	endtask

	task automatic drain;
		while (word_q.size() != 0 || decoded_q.size() != 0 || s_tvalid) @(negedge clk);
		repeat (LAT + 4) @(negedge clk);
	endtask

	// Word with up to nerr random bit errors over a zero codeword base
	function automatic word_t noisy_word(int nerr);
		word_t w;
		w = '0;
		for (int i = 0; i < nerr; i++) w[$urandom_range(0, WORD_BITS-1)] ^= 1'b1;
		return w;
	endfunction

	task automatic run_phase(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0) queue_word(word_t'($urandom));
			else queue_word(noisy_word($urandom_range(0, cur_t + 1)));
		end
	endtask

	initial begin
		int t_set[8];
		int p_set[8];
		t_set = '{1, 2, 3, 4, 0, 5, 7, 3};
		p_set = '{37, 37, 61, 37, 0, 127, 41, 101};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		// Directed: extremes, single and multiple errors at default settings
		queue_word('0);
		queue_word('1);
		queue_word(word_t'(1));
		queue_word(word_t'(1) << 30);
		queue_word(word_t'(32'h5555_5555));
		queue_word(word_t'(32'h2AAA_AAAA));
		queue_word(word_t'(3));
		queue_word(word_t'(32'h4000_0011));
		queue_word(word_t'(32'h0001_0101));
		queue_word(word_t'(32'h0F00_00F0));
		drain();
		// Phases over capability and polynomial settings, extremes included
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_MAX_CORRECT, t_set[ph]);
			reg_write(REG_FIELD_POLY, p_set[ph]);
			queue_word('1);
			queue_word(noisy_word(2));
			if (ph == 2) begin
				hold_cycles = 300;
				run_phase(60);
			end else begin
				run_phase(220);
			end
			drain();
		end
		if (errors == 0) $display("bch_peterson_chien_decoder_top_test passed");
		else $display("bch_peterson_chien_decoder_top_test failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("bch_peterson_chien_decoder_top_test failed");
		$finish;
	end
endmodule

FILE: sim.f
rtl/bpc_pkg.sv
rtl/bpc_gf_inv.sv
rtl/bpc_locator.sv
rtl/bpc_lane.sv
rtl/bpc_merge.sv
rtl/bch_peterson_chien_decoder_top.sv
tb/sv/bch_peterson_chien_decoder_top_test.sv
